// File: hdl/axis_angle_point_rotation_defines.svh
// assertion macros shared by the rotation block
`ifndef AXIS_ANGLE_POINT_ROTATION_DEFINES_SVH
`define AXIS_ANGLE_POINT_ROTATION_DEFINES_SVH

// same-cycle implication, checked outside reset
`define AAPR_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define AAPR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/aapr_pkg.sv
// types and constants of the axis-angle point rotation block
package aapr_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_ANGLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_ANGLE = 3'd4;

  localparam logic signed [15:0] RST_AXIS_X    = 16'sd1;
  localparam logic signed [15:0] RST_AXIS_Y    = 16'sd0;
  localparam logic signed [15:0] RST_AXIS_Z    = 16'sd0;
  localparam logic signed [15:0] RST_SIN_ANGLE = 16'sd0;
  localparam logic signed [15:0] RST_COS_ANGLE = 16'sd16384;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;
  } out_t;

  typedef enum logic [2:0] {
    BLD_IDLE,
    BLD_SQRT,
    BLD_DIV_LOAD,
    BLD_DIV,
    BLD_COEF
  } bld_state_t;

  typedef struct packed {
    logic start;
    logic abort;
  } bld_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bld_stat_t;

endpackage

// File: hdl/aapr_build.sv
// matrix builder: axis normalization by iterative sqrt and division, then coefficients
module aapr_build #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  aapr_pkg::bld_ctrl_t                    ctrl,
  input  logic signed [15:0]                     axis_x,
  input  logic signed [15:0]                     axis_y,
  input  logic signed [15:0]                     axis_z,
  input  logic signed [15:0]                     sin_angle,
  input  logic signed [15:0]                     cos_angle,
  output aapr_pkg::bld_stat_t                    stat,
  output logic [8:0][COEF_FRAC_BITS+1:0]         coef
);
  import aapr_pkg::*;

  localparam int F    = COEF_FRAC_BITS;
  localparam int CW   = F + 2;
  localparam int NW   = F + 32;
  localparam int PW   = 2 * CW;
  localparam int RW   = PW - F;
  localparam int TW   = RW + 17;
  localparam int SW   = F + 18;
  localparam int AW   = TW + 1;
  localparam int QW   = AW - 14;
  localparam int CNTW = $clog2(NW);

  localparam logic signed [CW-1:0] ONE_U  = CW'(1) << F;
  localparam logic [NW-1:0]        ONE_N  = NW'(1) << F;
  localparam logic signed [PW-1:0] PHALF  = PW'(1) << (F - 1);
  localparam logic signed [AW-1:0] AHALF  = AW'(1) << 13;
  localparam logic signed [QW-1:0] ONE_Q  = QW'(1) << F;
  localparam logic signed [QW-1:0] MONE_Q = -(QW'(1) << F);

  bld_state_t state_r, state_nxt;

  logic [CNTW-1:0]        cnt_r;
  logic [63:0]            rad_r;
  logic [33:0]            rem_r;
  logic [31:0]            root_r;
  logic [31:0]            drem_r;
  logic [NW-1:0]          num_r;
  logic [NW-1:0]          quot_r;
  logic [1:0]             ci_r;
  logic signed [CW-1:0]   ux_r, uy_r, uz_r;
  logic [1:0]             ri_r, cj_r, ph_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [SW-1:0]   side_r;
  logic signed [TW-1:0]   t_r;
  logic [8:0][CW-1:0]     coef_r;

  function automatic logic signed [CW-1:0] sel_u(input logic [1:0] idx,
      input logic signed [CW-1:0] a, input logic signed [CW-1:0] b,
      input logic signed [CW-1:0] c);
    logic signed [CW-1:0] r;
    case (idx)
      2'd0:    r = a;
      2'd1:    r = b;
      default: r = c;
    endcase
    return r;
  endfunction

  // squared length of the axis
  logic signed [31:0] sqx, sqy, sqz;
  logic [31:0]        sum_c;
  assign sqx   = axis_x * axis_x;
  assign sqy   = axis_y * axis_y;
  assign sqz   = axis_z * axis_z;
  assign sum_c = 32'(sqx) + 32'(sqy) + 32'(sqz);

  // one root bit per cycle
  logic [35:0] rem_sh, trial;
  logic        sq_ge;
  logic [33:0] rem_new;
  assign rem_sh  = {rem_r, rad_r[63:62]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign sq_ge   = rem_sh >= trial;
  assign rem_new = sq_ge ? 34'(rem_sh - trial) : rem_sh[33:0];

  // one quotient bit per cycle
  logic signed [15:0] a_sel;
  logic [15:0]        mag;
  logic [NW-1:0]      num_load;
  logic [32:0]        drem_sh;
  logic               dv_ge;
  logic [31:0]        drem_new;
  logic [NW-1:0]      q_fin, q_cl;
  logic signed [CW-1:0] u_mag, u_new;

  always_comb begin
    case (ci_r)
      2'd0:    a_sel = axis_x;
      2'd1:    a_sel = axis_y;
      default: a_sel = axis_z;
    endcase
  end

  assign mag      = a_sel[15] ? (~a_sel + 16'd1) : a_sel;
  assign num_load = (NW'(mag) << (F + 16)) + NW'(root_r[31:1]);
  assign drem_sh  = {drem_r, num_r[NW-1]};
  assign dv_ge    = drem_sh >= {1'b0, root_r};
  assign drem_new = dv_ge ? 32'(drem_sh - {1'b0, root_r}) : drem_sh[31:0];
  assign q_fin    = {quot_r[NW-2:0], dv_ge};
  assign q_cl     = (q_fin > ONE_N) ? ONE_N : q_fin;
  assign u_mag    = CW'(q_cl);
  assign u_new    = a_sel[15] ? -u_mag : u_mag;

  // coefficient arithmetic
  logic signed [CW-1:0] ui, uj, uk;
  logic [1:0]           kk, cj_inc;
  logic                 plus, diag;
  logic signed [SW-1:0] us, side_c;
  logic signed [RW-1:0] rnd;
  logic signed [16:0]   omc;
  logic signed [AW-1:0] acc;
  logic signed [QW-1:0] res_q, res_cl;
  logic [3:0]           k_idx;

  assign ui     = sel_u(ri_r, ux_r, uy_r, uz_r);
  assign uj     = sel_u(cj_r, ux_r, uy_r, uz_r);
  assign kk     = 2'd3 - ri_r - cj_r;
  assign uk     = sel_u(kk, ux_r, uy_r, uz_r);
  assign cj_inc = (cj_r == 2'd2) ? 2'd0 : 2'(cj_r + 2'd1);
  assign plus   = ri_r == cj_inc;
  assign diag   = ri_r == cj_r;
  assign us     = uk * sin_angle;
  assign side_c = diag ? (SW'(cos_angle) <<< F) : (plus ? us : -us);
  assign rnd    = RW'((prod_r + PHALF) >>> F);
  assign omc    = 17'sd16384 - 17'(cos_angle);
  assign acc    = AW'(t_r) + AW'(side_r);
  assign res_q  = QW'((acc + AHALF) >>> 14);
  assign res_cl = (res_q > ONE_Q) ? ONE_Q : ((res_q < MONE_Q) ? MONE_Q : res_q);
  assign k_idx  = {ri_r, 1'b0} + 4'(ri_r) + 4'(cj_r);

  logic last_coef;
  assign last_coef = (ph_r == 2'd2) && (ri_r == 2'd2) && (cj_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BLD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    stat.done = 1'b0;
    unique case (state_r)
      BLD_IDLE: begin
        if (ctrl.start) begin
          state_nxt = (sum_c == 32'd0) ? BLD_COEF : BLD_SQRT;
        end
      end
      BLD_SQRT: begin
        if (cnt_r == CNTW'(31)) state_nxt = BLD_DIV_LOAD;
      end
      BLD_DIV_LOAD: state_nxt = BLD_DIV;
      BLD_DIV: begin
        if (cnt_r == CNTW'(NW - 1)) begin
          state_nxt = (ci_r == 2'd2) ? BLD_COEF : BLD_DIV_LOAD;
        end
      end
      BLD_COEF: begin
        if (last_coef) begin
          state_nxt = BLD_IDLE;
          stat.done = 1'b1;
        end
      end
      default: state_nxt = BLD_IDLE;
    endcase
    if (ctrl.abort) begin
      state_nxt = BLD_IDLE;
      stat.done = 1'b0;
    end
    stat.busy = state_r != BLD_IDLE;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BLD_IDLE: begin
        rad_r  <= {sum_c, 32'd0};
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
        ci_r   <= '0;
        ri_r   <= '0;
        cj_r   <= '0;
        ph_r   <= '0;
        if (sum_c == 32'd0) begin
          // degenerate axis falls back to x
          ux_r <= ONE_U;
          uy_r <= '0;
          uz_r <= '0;
        end
      end
      BLD_SQRT: begin
        rad_r  <= rad_r << 2;
        rem_r  <= rem_new;
        root_r <= {root_r[30:0], sq_ge};
        cnt_r  <= (cnt_r == CNTW'(31)) ? '0 : CNTW'(cnt_r + 1'b1);
      end
      BLD_DIV_LOAD: begin
        num_r  <= num_load;
        drem_r <= '0;
        quot_r <= '0;
        cnt_r  <= '0;
      end
      BLD_DIV: begin
        num_r  <= num_r << 1;
        drem_r <= drem_new;
        quot_r <= q_fin;
        cnt_r  <= CNTW'(cnt_r + 1'b1);
        if (cnt_r == CNTW'(NW - 1)) begin
          case (ci_r)
            2'd0:    ux_r <= u_new;
            2'd1:    uy_r <= u_new;
            default: uz_r <= u_new;
          endcase
          ci_r <= 2'(ci_r + 2'd1);
        end
      end
      BLD_COEF: begin
        case (ph_r)
          2'd0: begin
            prod_r <= ui * uj;
            side_r <= side_c;
            ph_r   <= 2'd1;
          end
          2'd1: begin
            t_r  <= rnd * omc;
            ph_r <= 2'd2;
          end
          default: begin
            coef_r[k_idx] <= CW'(res_cl);
            ph_r          <= 2'd0;
            if (cj_r == 2'd2) begin
              cj_r <= 2'd0;
              ri_r <= 2'(ri_r + 2'd1);
            end else begin
              cj_r <= 2'(cj_r + 2'd1);
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  assign coef = coef_r;

endmodule

// File: hdl/axis_angle_point_rotation.sv
// Axis-angle point rotation: each Q16.16 point is multiplied by a cached 3x3
// Rodrigues matrix and the rounded, saturated result leaves through a
// three-stage pipeline (nine parallel products, row sums, rounding and
// saturation) that takes one point per cycle unless the output stalls or the
// matrix is being rebuilt. After reset and after every configuration write to
// one of the five defined indices the matrix is rebuilt by a sequential unit:
// setup, square root, bit-serial division of each axis component and the
// nine coefficients, while in_ready stays low.
module axis_angle_point_rotation #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  aapr_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output aapr_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [aapr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]                    cfg_data
);
  import aapr_pkg::*;
  `include "axis_angle_point_rotation_defines.svh"

  localparam int F  = COEF_FRAC_BITS;
  localparam int CW = F + 2;
  localparam int PW = CW + 32;
  localparam int AW = PW + 2;

  localparam logic signed [AW-1:0] OHALF = AW'(1) << (F - 1);
  localparam logic signed [AW-1:0] OMAX  = AW'(32'sh7FFFFFFF);
  localparam logic signed [AW-1:0] OMIN  = AW'($signed(32'h80000000));

  logic signed [15:0] axis_x_r, axis_y_r, axis_z_r, sin_r, cos_r;
  logic               mat_valid_r;
  logic               cfg_hit;
  bld_ctrl_t          ctrl;
  bld_stat_t          stat;
  logic [8:0][CW-1:0] coef;

  always_comb begin
    unique case (cfg_idx)
      CFG_AXIS_X, CFG_AXIS_Y, CFG_AXIS_Z, CFG_SIN_ANGLE, CFG_COS_ANGLE:
        cfg_hit = cfg_we;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_x_r <= RST_AXIS_X;
      axis_y_r <= RST_AXIS_Y;
      axis_z_r <= RST_AXIS_Z;
      sin_r    <= RST_SIN_ANGLE;
      cos_r    <= RST_COS_ANGLE;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_AXIS_X:    axis_x_r <= cfg_data;
        CFG_AXIS_Y:    axis_y_r <= cfg_data;
        CFG_AXIS_Z:    axis_z_r <= cfg_data;
        CFG_SIN_ANGLE: sin_r    <= cfg_data;
        CFG_COS_ANGLE: cos_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_valid_r <= 1'b0;
    end else if (cfg_hit) begin
      mat_valid_r <= 1'b0;
    end else if (stat.done) begin
      mat_valid_r <= 1'b1;
    end
  end

  // rebuild as soon as the matrix goes stale; a write restarts it
  assign ctrl.abort = cfg_hit;
  assign ctrl.start = !mat_valid_r && !stat.busy && !cfg_hit;

  aapr_build #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_build (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .axis_x   (axis_x_r),
    .axis_y   (axis_y_r),
    .axis_z   (axis_z_r),
    .sin_angle(sin_r),
    .cos_angle(cos_r),
    .stat     (stat),
    .coef     (coef)
  );

  // pipeline handshake
  logic v1_r, v2_r, out_valid_r;
  logic rdy1, rdy2, rdy3, in_fire;

  assign rdy3     = !out_valid_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = mat_valid_r && rdy1;
  assign in_fire  = in_valid && in_ready;

  logic signed [31:0]   pv [3];
  logic signed [PW-1:0] prod_r [9];
  logic signed [AW-1:0] row_r [3];
  out_t                 out_r;

  assign pv[0] = in_data.point_x;
  assign pv[1] = in_data.point_y;
  assign pv[2] = in_data.point_z;

  for (genvar k = 0; k < 9; k++) begin : g_prod
    always_ff @(posedge clk) begin
      if (in_fire) begin
        prod_r[k] <= $signed(coef[k]) * pv[k % 3];
      end
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    always_ff @(posedge clk) begin
      if (v1_r && rdy2) begin
        row_r[r] <= AW'(prod_r[3*r]) + AW'(prod_r[3*r+1]) + AW'(prod_r[3*r+2]);
      end
    end
  end

  function automatic logic signed [31:0] rnd_sat(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] s;
    s = (v + OHALF) >>> F;
    if (s > OMAX) return 32'sh7FFFFFFF;
    if (s < OMIN) return $signed(32'h80000000);
    return 32'(s);
  endfunction

  always_ff @(posedge clk) begin
    if (v2_r && rdy3) begin
      out_r.rotated_x <= rnd_sat(row_r[0]);
      out_r.rotated_y <= rnd_sat(row_r[1]);
      out_r.rotated_z <= rnd_sat(row_r[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_fire;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) out_valid_r <= v2_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `AAPR_ASSERT_NOW(a_done_stale, clk, rst_n, stat.done, !mat_valid_r,
    "matrix finished while already valid")
  `AAPR_ASSERT_NEXT(a_cfg_invalidates, clk, rst_n, cfg_hit, !mat_valid_r,
    "configuration write left matrix valid")
  `AAPR_ASSERT_NOW(a_busy_stale, clk, rst_n, stat.busy, !mat_valid_r,
    "builder running while matrix valid")
  `AAPR_ASSERT_NEXT(a_stage_to_out, clk, rst_n, v2_r && rdy3, out_valid,
    "pipeline transaction lost before output")

endmodule
